// ===== rtl/core/cat_pkg.sv =====
// shared types, codes and helpers for the coalescing aging table
package cat_pkg;

   localparam int POS_W    = 16;
   localparam int AMT_W    = 24;
   localparam int LIFE_W   = 16;
   localparam int RADIUS_W = 35;
   localparam int CSR_IDX_W = 4;
   localparam int SQ_W     = 32;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET   = 35'd147456;
   localparam logic [LIFE_W-1:0]   LIFETIME_RESET = 16'd1000;
   localparam logic [AMT_W-1:0]    AMOUNT_MAX     = 24'hFFFFFF;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MERGE_RADIUS_SQ = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_LIFETIME  = 4'd1;

   // action codes reported with each result
   typedef enum logic [2:0] {
      ACT_MERGED  = 3'd0,
      ACT_NEW     = 3'd1,
      ACT_FOLDED  = 3'd2,
      ACT_IGNORED = 3'd3,
      ACT_TICK    = 3'd4
   } cat_action_type;

   // one table entry as stored in the entry memory
   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [AMT_W-1:0]        amount;
      logic [LIFE_W-1:0]       life;
   } cat_entry_type;

   // saturating amount add
   function automatic logic [AMT_W-1:0] sat_add(input logic [AMT_W-1:0] a,
                                                input logic [AMT_W-1:0] b);
      logic [AMT_W:0] sum;
      begin
         sum = {1'b0, a} + {1'b0, b};
         sat_add = sum[AMT_W] ? AMOUNT_MAX : sum[AMT_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/coalescing_aging_table.sv =====
// coalescing aging table: top level with sequencer, squaring unit and entry memory

// An add item scans the live entries through one squaring multiplier, in
// the steps x square, y square and distance compare per live entry, then
// writes the chosen entry in a final step; the result strobe follows. A
// zero-amount add, or a tick on an empty table, reports in the cycle after
// start. A tick walks the live entries from the top through the single
// memory read port, with a check step for every entry and a further move
// step for each expired entry that is replaced by the last entry. The
// result strobe rsp_valid is high for exactly one cycle and must be taken
// then; busy is already low in that cycle, so the next item may start at
// once. Configuration writes are taken at any time but belong to idle
// periods; csr_ready is always high.
module coalescing_aging_table
   import cat_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_command,
   input  logic signed [POS_W-1:0]    req_pos_x,
   input  logic signed [POS_W-1:0]    req_pos_y,
   input  logic [AMT_W-1:0]           req_add_amount,
   input  logic [LIFE_W-1:0]          req_elapsed,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_action,
   output logic [3:0]                 rsp_slot,
   output logic [4:0]                 rsp_live_entries,
   output logic [4:0]                 rsp_removed,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [RADIUS_W-1:0]        csr_wdata
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_DX,
      ST_ADD_DY,
      ST_ADD_CMP,
      ST_ADD_WR,
      ST_TICK_CHK,
      ST_TICK_MV
   } state_type;

   state_type               state_ff, state_in;
   logic [RADIUS_W-1:0]     radius_ff, radius_in;
   logic [LIFE_W-1:0]       lifetime_ff, lifetime_in;
   logic [OCC_W-1:0]        occ_ff, occ_in;
   logic [OCC_W-1:0]        removed_ff, removed_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    found_ff, found_in;
   logic [RADIUS_W-1:0]     best_d_ff, best_d_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   cat_entry_type           best_ent_ff, best_ent_in;
   logic [IDX_W-1:0]        old_idx_ff, old_idx_in;
   cat_entry_type           old_ent_ff, old_ent_in;
   logic signed [POS_W-1:0] px_ff, px_in;
   logic signed [POS_W-1:0] py_ff, py_in;
   logic [AMT_W-1:0]        amt_ff, amt_in;
   logic [LIFE_W-1:0]       dt_ff, dt_in;
   logic [SQ_W-1:0]         sqx_ff, sqx_in;
   logic [SQ_W-1:0]         sqy_ff, sqy_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   cat_action_type          rsp_action_ff, rsp_action_in;
   logic [3:0]              rsp_slot_ff, rsp_slot_in;
   logic [4:0]              rsp_live_ff, rsp_live_in;
   logic [4:0]              rsp_removed_ff, rsp_removed_in;

   // entry memory with one write and one registered read port
   cat_entry_type           entry_mem [CAPACITY];
   cat_entry_type           rdata_ff;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   cat_entry_type           mem_wdata;
   logic [IDX_W-1:0]        mem_raddr;

   // shared squaring unit and scan helpers
   logic signed [POS_W-1:0] sq_a;
   logic signed [POS_W-1:0] sq_b;
   logic signed [POS_W:0]   sq_diff;
   logic [POS_W:0]          sq_abs;
   logic [SQ_W-1:0]         sq_prod;
   logic [RADIUS_W-1:0]     dist_sq;
   logic [OCC_W-1:0]        occ_m1;
   logic [IDX_W-1:0]        last_idx;
   logic [LIFE_W-1:0]       new_life;
   logic                    tick_adv;
   cat_entry_type           ent_tmp;

   assign occ_m1   = occ_ff - OCC_W'(1);
   assign last_idx = occ_m1[IDX_W-1:0];

   // one multiplier squares |dx| or |dy| depending on the step
   assign sq_a    = (state_ff == ST_ADD_DY) ? rdata_ff.pos_y : rdata_ff.pos_x;
   assign sq_b    = (state_ff == ST_ADD_DY) ? py_ff : px_ff;
   assign sq_diff = {sq_a[POS_W-1], sq_a} - {sq_b[POS_W-1], sq_b};
   assign sq_abs  = sq_diff[POS_W] ? (~sq_diff + 1'b1) : sq_diff;
   assign sq_prod = sq_abs[POS_W-1:0] * sq_abs[POS_W-1:0];
   assign dist_sq = RADIUS_W'(sqx_ff) + RADIUS_W'(sqy_ff);
   assign new_life = (rdata_ff.life > dt_ff) ? (rdata_ff.life - dt_ff) : '0;

   // sequencer next-state logic
   always_comb begin
      state_in       = state_ff;
      radius_in      = radius_ff;
      lifetime_in    = lifetime_ff;
      occ_in         = occ_ff;
      removed_in     = removed_ff;
      idx_in         = idx_ff;
      found_in       = found_ff;
      best_d_in      = best_d_ff;
      best_idx_in    = best_idx_ff;
      best_ent_in    = best_ent_ff;
      old_idx_in     = old_idx_ff;
      old_ent_in     = old_ent_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      amt_in         = amt_ff;
      dt_in          = dt_ff;
      sqx_in         = sqx_ff;
      sqy_in         = sqy_ff;
      rsp_valid_in   = 1'b0;
      rsp_action_in  = rsp_action_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_live_in    = rsp_live_ff;
      rsp_removed_in = rsp_removed_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff;
      mem_wdata      = rdata_ff;
      mem_raddr      = idx_ff;
      tick_adv       = 1'b0;
      ent_tmp        = best_ent_ff;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_MERGE_RADIUS_SQ: radius_in = csr_wdata;
            CSR_ENTRY_LIFETIME:  lifetime_in = csr_wdata[LIFE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               px_in  = req_pos_x;
               py_in  = req_pos_y;
               amt_in = req_add_amount;
               dt_in  = req_elapsed;
               if (req_command) begin
                  // tick walks from the highest live index down
                  removed_in = '0;
                  if (occ_ff == '0) begin
                     rsp_valid_in   = 1'b1;
                     rsp_action_in  = ACT_TICK;
                     rsp_slot_in    = '0;
                     rsp_live_in    = 5'(occ_ff);
                     rsp_removed_in = '0;
                  end else begin
                     idx_in    = last_idx;
                     mem_raddr = last_idx;
                     state_in  = ST_TICK_CHK;
                  end
               end else if (req_add_amount == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_action_in  = ACT_IGNORED;
                  rsp_slot_in    = '0;
                  rsp_live_in    = 5'(occ_ff);
                  rsp_removed_in = '0;
               end else begin
                  found_in  = 1'b0;
                  best_d_in = radius_ff;
                  idx_in    = '0;
                  mem_raddr = '0;
                  state_in  = (occ_ff == '0) ? ST_ADD_WR : ST_ADD_DX;
               end
            end
         end

         ST_ADD_DX: begin
            sqx_in   = sq_prod;
            state_in = ST_ADD_DY;
         end

         ST_ADD_DY: begin
            sqy_in   = sq_prod;
            state_in = ST_ADD_CMP;
         end

         ST_ADD_CMP: begin
            // nearest entry inside the radius, lowest index on ties
            if (dist_sq < best_d_ff) begin
               best_d_in   = dist_sq;
               best_idx_in = idx_ff;
               best_ent_in = rdata_ff;
               found_in    = 1'b1;
            end
            // least life seen so far, first on ties
            if ((idx_ff == '0) || (rdata_ff.life < old_ent_ff.life)) begin
               old_idx_in = idx_ff;
               old_ent_in = rdata_ff;
            end
            if (OCC_W'(idx_ff) == occ_m1) begin
               state_in = ST_ADD_WR;
            end else begin
               idx_in    = idx_ff + 1'b1;
               mem_raddr = idx_ff + 1'b1;
               state_in  = ST_ADD_DX;
            end
         end

         ST_ADD_WR: begin
            mem_we         = 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_removed_in = '0;
            if (found_ff) begin
               ent_tmp        = best_ent_ff;
               ent_tmp.amount = sat_add(best_ent_ff.amount, amt_ff);
               ent_tmp.life   = lifetime_ff;
               mem_waddr      = best_idx_ff;
               rsp_action_in  = ACT_MERGED;
               rsp_slot_in    = 4'(best_idx_ff);
            end else if (occ_ff == OCC_W'(CAPACITY)) begin
               ent_tmp        = old_ent_ff;
               ent_tmp.amount = sat_add(old_ent_ff.amount, amt_ff);
               mem_waddr      = old_idx_ff;
               rsp_action_in  = ACT_FOLDED;
               rsp_slot_in    = 4'(old_idx_ff);
            end else begin
               ent_tmp.pos_x  = px_ff;
               ent_tmp.pos_y  = py_ff;
               ent_tmp.amount = amt_ff;
               ent_tmp.life   = lifetime_ff;
               mem_waddr      = occ_ff[IDX_W-1:0];
               occ_in         = occ_ff + 1'b1;
               rsp_action_in  = ACT_NEW;
               rsp_slot_in    = 4'(occ_ff);
            end
            mem_wdata   = ent_tmp;
            rsp_live_in = 5'(occ_in);
            state_in    = ST_IDLE;
         end

         ST_TICK_CHK: begin
            if (new_life != '0) begin
               ent_tmp      = rdata_ff;
               ent_tmp.life = new_life;
               mem_we       = 1'b1;
               mem_wdata    = ent_tmp;
               tick_adv     = 1'b1;
            end else begin
               removed_in = removed_ff + 1'b1;
               if (idx_ff == last_idx) begin
                  occ_in   = occ_m1;
                  tick_adv = 1'b1;
               end else begin
                  // fetch the last entry to fill this slot
                  mem_raddr = last_idx;
                  state_in  = ST_TICK_MV;
               end
            end
         end

         ST_TICK_MV: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_ff;
            occ_in    = occ_m1;
            tick_adv  = 1'b1;
         end

         default: state_in = ST_IDLE;
      endcase

      // step the tick walk down or finish it
      if (tick_adv) begin
         if (idx_ff == '0) begin
            rsp_valid_in   = 1'b1;
            rsp_action_in  = ACT_TICK;
            rsp_slot_in    = '0;
            rsp_live_in    = 5'(occ_in);
            rsp_removed_in = 5'(removed_in);
            state_in       = ST_IDLE;
         end else begin
            idx_in    = idx_ff - 1'b1;
            mem_raddr = idx_ff - 1'b1;
            state_in  = ST_TICK_CHK;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      removed_ff     <= removed_in;
      idx_ff         <= idx_in;
      found_ff       <= found_in;
      best_d_ff      <= best_d_in;
      best_idx_ff    <= best_idx_in;
      best_ent_ff    <= best_ent_in;
      old_idx_ff     <= old_idx_in;
      old_ent_ff     <= old_ent_in;
      px_ff          <= px_in;
      py_ff          <= py_in;
      amt_ff         <= amt_in;
      dt_ff          <= dt_in;
      sqx_ff         <= sqx_in;
      sqy_ff         <= sqy_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_live_ff    <= rsp_live_in;
      rsp_removed_ff <= rsp_removed_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= RADIUS_RESET;
         lifetime_ff  <= LIFETIME_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         lifetime_ff  <= lifetime_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= entry_mem[mem_raddr];
   end

   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = rsp_action_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_live_entries = rsp_live_ff;
   assign rsp_removed      = rsp_removed_ff;

   // occupancy never exceeds the table size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(CAPACITY))
      else $error("occupancy above capacity");

   // a result is only shown once the sequencer is back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // adds never report expired entries
   a_add_removed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action != ACT_TICK)) |-> (rsp_removed == '0))
      else $error("add reported removed entries");

   // a tick walk starts with a cleared removal count
   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      (busy && !$past(busy) && (state_ff == ST_TICK_CHK)) |-> (removed_ff == '0))
      else $error("tick removal count not cleared");

endmodule
